@@ hw/rtl/svmh_pkg.sv @@
// Shared types, constants and tables for the star velocity-map histogram.
// No dependencies; used by every module of the block.
`default_nettype none

package svmh_pkg;

    // Default geometry of the histogram store
    localparam int QUADRANTS_DEF   = 4;
    localparam int VR_BINS_DEF     = 80;
    localparam int VA_BINS_DEF     = 100;
    localparam int COUNT_WIDTH_DEF = 32;

    // Velocity binning: bins of VBIN_WIDTH km/s from -VBIN_LOW km/s.
    // floor(t / 3) for t below 768 is (t * 683) >> 11.
    localparam int VBIN_LOW         = 150;
    localparam int VBIN_WIDTH       = 3;
    localparam int VBIN_RECIP       = 683;
    localparam int VBIN_RECIP_SHIFT = 11;
    localparam int BIN_W            = 8;

    localparam int CORDIC_STEPS   = 20;
    localparam int ANG_W          = 25;
    localparam int LAT_RIGHT_ANGLE = 90 * 65536;

    localparam int JOB_FIFO_DEPTH = 2;

    // Register reset values
    localparam logic [31:0] SUN_DISTANCE_RST      = 32'd655360;
    localparam logic [31:0] CIRCULAR_VELOCITY_RST = 32'd0;
    localparam logic [31:0] VELOCITY_UNIT_RST     = 32'd6514000;
    localparam logic [31:0] SELECTION_RADIUS_RST  = 32'd32768;
    localparam logic [22:0] LATITUDE_LIMIT_RST    = 23'd655360;

    typedef enum logic [2:0] {
        CFG_SUN_DISTANCE      = 3'd0,
        CFG_CIRCULAR_VELOCITY = 3'd1,
        CFG_VELOCITY_UNIT     = 3'd2,
        CFG_SELECTION_RADIUS  = 3'd3,
        CFG_LATITUDE_LIMIT    = 3'd4
    } cfg_index_t;

    typedef enum logic {
        OP_BIN  = 1'b0,
        OP_READ = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        JOB_REJECT = 2'd0,
        JOB_COUNT  = 2'd1,
        JOB_READ   = 2'd2
    } job_kind_t;

    typedef struct packed {
        logic [31:0] sun_distance;
        logic [31:0] circular_velocity;
        logic [31:0] velocity_unit;
        logic [31:0] selection_radius;
        logic [22:0] latitude_limit;
    } svmh_cfg_t;

    typedef struct packed {
        job_kind_t        kind;
        logic [1:0]       quad;
        logic [BIN_W-1:0] vr;
        logic [BIN_W-1:0] va;
        logic             in_range;
    } svmh_job_t;

    // atan(2^-i) in Q16.16 degrees
    function automatic logic [21:0] atan_deg(input logic [4:0] i);
        logic [21:0] r;
        case (i)
            5'd0:    r = 22'd2949120;
            5'd1:    r = 22'd1740967;
            5'd2:    r = 22'd919879;
            5'd3:    r = 22'd466945;
            5'd4:    r = 22'd234379;
            5'd5:    r = 22'd117304;
            5'd6:    r = 22'd58666;
            5'd7:    r = 22'd29335;
            5'd8:    r = 22'd14668;
            5'd9:    r = 22'd7334;
            5'd10:   r = 22'd3667;
            5'd11:   r = 22'd1833;
            5'd12:   r = 22'd917;
            5'd13:   r = 22'd458;
            5'd14:   r = 22'd229;
            5'd15:   r = 22'd115;
            5'd16:   r = 22'd57;
            5'd17:   r = 22'd29;
            5'd18:   r = 22'd14;
            5'd19:   r = 22'd7;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/star_velocity_map_histogram_core.sv @@
// Star velocity-map histogram: top level with configuration registers.
// Instantiates svmh_front, svmh_fifo and svmh_back; depends on svmh_pkg.
//
// Usage:
//  - Requests enter through push/full. opcode 0 bins one star, opcode 1 reads
//    one histogram counter. Each request gives exactly one result.
//  - Results leave through empty/pop; the oldest result sits on the result
//    ports while empty is low.
//  - Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data; the
//    user must write them only while no request is in flight, which the block
//    itself does not enforce. cfg_ready is always high.
//  - A star that passes the radius cut holds the front end for a 32-step square
//    root and 20 CORDIC steps, and if it passes the latitude and quadrant cuts
//    too, for a second 32-step square root and two 64-step divisions.
//  - The back end handles a counter access in B_READ and B_UPD, a rejected star
//    in B_IDLE, and starts a request only once the result register is free.
//  - After reset the counter store, QUADRANTS*VR_BINS*VA_BINS entries (32000 by
//    default), is cleared one entry a cycle; full stays high then.
//  - When the receiver stops popping, the result register and a two-entry
//    queue fill up, then the front end stalls and full stays high.
`default_nettype none

module star_velocity_map_histogram_core #(
    parameter int QUADRANTS   = svmh_pkg::QUADRANTS_DEF,
    parameter int VR_BINS     = svmh_pkg::VR_BINS_DEF,
    parameter int VA_BINS     = svmh_pkg::VA_BINS_DEF,
    parameter int COUNT_WIDTH = svmh_pkg::COUNT_WIDTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         push,
    output logic        full,
    input  wire         opcode,
    input  wire  [31:0] pos_x,
    input  wire  [31:0] pos_y,
    input  wire  [31:0] pos_z,
    input  wire  [31:0] vel_x,
    input  wire  [31:0] vel_y,
    input  wire  [31:0] vel_z,
    input  wire  [1:0]  read_quadrant,
    input  wire  [6:0]  read_vr_bin,
    input  wire  [6:0]  read_va_bin,
    output logic        empty,
    input  wire         pop,
    output logic        accepted,
    output logic [1:0]  quadrant,
    output logic [6:0]  vr_bin,
    output logic [6:0]  va_bin,
    output logic [31:0] bin_count,
    output logic [31:0] total_counted,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [31:0] cfg_data
);

    svmh_pkg::svmh_cfg_t cfg_reg, cfg_next;
    svmh_pkg::svmh_job_t front_job, fifo_job;
    logic job_push, job_full, job_pop, job_empty, clearing;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                svmh_pkg::CFG_SUN_DISTANCE:      cfg_next.sun_distance      = cfg_data;
                svmh_pkg::CFG_CIRCULAR_VELOCITY: cfg_next.circular_velocity = cfg_data;
                svmh_pkg::CFG_VELOCITY_UNIT:     cfg_next.velocity_unit     = cfg_data;
                svmh_pkg::CFG_SELECTION_RADIUS:  cfg_next.selection_radius  = cfg_data;
                svmh_pkg::CFG_LATITUDE_LIMIT:    cfg_next.latitude_limit    = cfg_data[22:0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sun_distance      <= svmh_pkg::SUN_DISTANCE_RST;
            cfg_reg.circular_velocity <= svmh_pkg::CIRCULAR_VELOCITY_RST;
            cfg_reg.velocity_unit     <= svmh_pkg::VELOCITY_UNIT_RST;
            cfg_reg.selection_radius  <= svmh_pkg::SELECTION_RADIUS_RST;
            cfg_reg.latitude_limit    <= svmh_pkg::LATITUDE_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    svmh_front #(
        .QUADRANTS (QUADRANTS),
        .VR_BINS   (VR_BINS),
        .VA_BINS   (VA_BINS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .hold          (clearing),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .vel_x         (vel_x),
        .vel_y         (vel_y),
        .read_quadrant (read_quadrant),
        .read_vr_bin   (read_vr_bin),
        .read_va_bin   (read_va_bin),
        .cfg           (cfg_reg),
        .job_push      (job_push),
        .job_full      (job_full),
        .job           (front_job)
    );

    svmh_fifo #(
        .DEPTH (svmh_pkg::JOB_FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (job_push),
        .din   (front_job),
        .full  (job_full),
        .rd_en (job_pop),
        .dout  (fifo_job),
        .empty (job_empty)
    );

    svmh_back #(
        .QUADRANTS   (QUADRANTS),
        .VR_BINS     (VR_BINS),
        .VA_BINS     (VA_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_empty     (job_empty),
        .job_pop       (job_pop),
        .job           (fifo_job),
        .clearing      (clearing),
        .empty         (empty),
        .pop           (pop),
        .accepted      (accepted),
        .quadrant      (quadrant),
        .vr_bin        (vr_bin),
        .va_bin        (va_bin),
        .bin_count     (bin_count),
        .total_counted (total_counted)
    );

endmodule

`default_nettype wire

@@ hw/rtl/svmh_fifo.sv @@
// Short request queue between the classifier front and the histogram back end.
// Depends on svmh_pkg for the job type.
`default_nettype none

module svmh_fifo #(
    parameter int DEPTH = svmh_pkg::JOB_FIFO_DEPTH
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    wr_en,
    input  svmh_pkg::svmh_job_t    din,
    output logic                   full,
    input  wire                    rd_en,
    output svmh_pkg::svmh_job_t    dout,
    output logic                   empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    svmh_pkg::svmh_job_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/svmh_front.sv @@
// Front end: takes requests, applies the position cuts and works out quadrant and
// velocity bins with a shared multiplier, a bit-serial square root, CORDIC and divider.
// Depends on svmh_pkg.
`default_nettype none

module svmh_front #(
    parameter int QUADRANTS = svmh_pkg::QUADRANTS_DEF,
    parameter int VR_BINS   = svmh_pkg::VR_BINS_DEF,
    parameter int VA_BINS   = svmh_pkg::VA_BINS_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   hold,
    input  wire                   push,
    output logic                  full,
    input  wire                   opcode,
    input  wire  [31:0]           pos_x,
    input  wire  [31:0]           pos_y,
    input  wire  [31:0]           pos_z,
    input  wire  [31:0]           vel_x,
    input  wire  [31:0]           vel_y,
    input  wire  [1:0]            read_quadrant,
    input  wire  [6:0]            read_vr_bin,
    input  wire  [6:0]            read_va_bin,
    input  svmh_pkg::svmh_cfg_t   cfg,
    output logic                  job_push,
    input  wire                   job_full,
    output svmh_pkg::svmh_job_t   job
);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_SQ     = 15'b000000000000010,
        S_SQRT1  = 15'b000000000000100,
        S_CINIT  = 15'b000000000001000,
        S_CORDIC = 15'b000000000010000,
        S_LAT    = 15'b000000000100000,
        S_GSQ    = 15'b000000001000000,
        S_SQRT2  = 15'b000000010000000,
        S_VINIT  = 15'b000000100000000,
        S_VMUL   = 15'b000001000000000,
        S_DIV1   = 15'b000010000000000,
        S_DIV2   = 15'b000100000000000,
        S_SMUL   = 15'b001000000000000,
        S_BIN    = 15'b010000000000000,
        S_EMIT   = 15'b100000000000000
    } fstate_t;

    localparam int BW = svmh_pkg::BIN_W;
    localparam int ANG_W_L = svmh_pkg::ANG_W;
    localparam logic [6:0] SqrtLast   = 7'd31;
    localparam logic [6:0] DivLast    = 7'd63;
    localparam logic [6:0] CordicLast = 7'(svmh_pkg::CORDIC_STEPS - 1);
    localparam logic signed [65:0] BinLow = 66'(svmh_pkg::VBIN_LOW) <<< 32;
    localparam logic signed [65:0] VrSpan = 66'(VR_BINS * svmh_pkg::VBIN_WIDTH) <<< 32;
    localparam logic signed [65:0] VaSpan = 66'(VA_BINS * svmh_pkg::VBIN_WIDTH) <<< 32;
    localparam logic signed [65:0] VaLimit = 66'sd1 <<< 62;
    localparam logic signed [ANG_W_L-1:0] RightAngle = ANG_W_L'(svmh_pkg::LAT_RIGHT_ANGLE);

    fstate_t state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;

    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [31:0] vx_reg, vx_next, vy_reg, vy_next;
    logic [31:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic signed [65:0] prod_reg, acc_reg, acc_next, acc2_reg, acc2_next;
    logic signed [65:0] na_reg, na_next, vr_reg, vr_next, d_reg, d_next;
    logic [63:0] rad_reg, rad_next;
    logic [31:0] root_reg, root_next;
    logic [33:0] rem_reg, rem_next;
    logic signed [59:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ANG_W_L-1:0] ang_reg, ang_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [31:0] drem_reg, drem_next;
    logic dneg_reg, dneg_next;
    logic signed [31:0] srv_reg, srv_next, sav_reg, sav_next;
    logic [1:0] k_reg, k_next;
    svmh_pkg::svmh_job_t job_reg, job_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_w;
    logic [35:0] rem_t, trial, rem_sub;
    logic sq_ge;
    logic [33:0] rem_step;
    logic [31:0] root_step;
    logic [32:0] div_t;
    logic div_ge;
    logic [31:0] drem_step;
    logic [63:0] dvd_step;
    logic [4:0] csh;
    logic signed [59:0] xs, ys;
    logic signed [ANG_W_L-1:0] atan_w;
    logic signed [34:0] dxq, dyq, ndx;
    logic [1:0] k_w;
    logic signed [65:0] offr, offd, va_w, cv_ext;
    logic [19:0] bin_pr, bin_pa;
    logic [BW-1:0] bin_i, bin_j;
    logic signed [32:0] dy_w;
    logic signed [65:0] sum_w, dif_w;
    logic [63:0] ax_mag, ay_mag, az_mag;

    function automatic logic signed [31:0] sat_quot(input logic [63:0] q, input logic neg);
        logic signed [31:0] r;
        if (!neg)
        begin
            r = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
        else
        begin
            r = (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(~q[31:0] + 32'd1);
        end
        return r;
    endfunction

    function automatic logic [63:0] mag66(input logic signed [65:0] v);
        logic signed [65:0] m;
        m = v[65] ? -v : v;
        return m[63:0];
    endfunction

    assign full     = (state_reg != S_IDLE) || hold;
    assign job_push = (state_reg == S_EMIT);
    assign job      = job_reg;

    assign ax_mag = mag66(66'($signed(pos_x)));
    assign ay_mag = mag66(66'($signed({1'b0, pos_y}) - $signed({1'b0, cfg.sun_distance})));
    assign az_mag = mag66(66'($signed(pos_z)));

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ:
            begin
                case (cnt_reg[1:0])
                    2'd0:    begin mul_a = {1'b0, ax_reg}; mul_b = {1'b0, ax_reg}; end
                    2'd1:    begin mul_a = {1'b0, ay_reg}; mul_b = {1'b0, ay_reg}; end
                    2'd2:    begin mul_a = {1'b0, az_reg}; mul_b = {1'b0, az_reg}; end
                    default:
                    begin
                        mul_a = {1'b0, cfg.selection_radius};
                        mul_b = {1'b0, cfg.selection_radius};
                    end
                endcase
            end
            S_GSQ:
            begin
                if (!cnt_reg[0])
                begin
                    mul_a = {px_reg[31], px_reg};
                    mul_b = {px_reg[31], px_reg};
                end
                else
                begin
                    mul_a = {py_reg[31], py_reg};
                    mul_b = {py_reg[31], py_reg};
                end
            end
            S_VMUL:
            begin
                case (cnt_reg[1:0])
                    2'd0:    begin mul_a = {px_reg[31], px_reg}; mul_b = {vx_reg[31], vx_reg}; end
                    2'd1:    begin mul_a = {py_reg[31], py_reg}; mul_b = {vy_reg[31], vy_reg}; end
                    2'd2:    begin mul_a = {px_reg[31], px_reg}; mul_b = {vy_reg[31], vy_reg}; end
                    default: begin mul_a = {py_reg[31], py_reg}; mul_b = {vx_reg[31], vx_reg}; end
                endcase
            end
            S_SMUL:
            begin
                mul_b = {1'b0, cfg.velocity_unit};
                mul_a = cnt_reg[0] ? {sav_reg[31], sav_reg} : {srv_reg[31], srv_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_w = mul_a * mul_b;

    // one result bit per cycle of the square root
    assign rem_t     = {rem_reg, rad_reg[63:62]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign sq_ge     = (rem_t >= trial);
    assign rem_sub   = rem_t - trial;
    assign rem_step  = sq_ge ? rem_sub[33:0] : rem_t[33:0];
    assign root_step = {root_reg[30:0], sq_ge};

    // restoring divide by root_reg, one quotient bit per cycle
    assign div_t     = {drem_reg, dvd_reg[63]};
    assign div_ge    = (div_t >= {1'b0, root_reg});
    assign drem_step = div_ge ? 32'(div_t - {1'b0, root_reg}) : div_t[31:0];
    assign dvd_step  = {dvd_reg[62:0], div_ge};

    // CORDIC vectoring step
    assign csh    = cnt_reg[4:0];
    assign xs     = cx_reg >>> csh;
    assign ys     = cy_reg >>> csh;
    assign atan_w = ANG_W_L'(svmh_pkg::atan_deg(csh));

    // quadrant from the angle of (dx, dy) around the sun point
    assign dy_w = {py_reg[31], py_reg} - $signed({1'b0, cfg.sun_distance});
    assign dxq  = 35'(px_reg);
    assign dyq  = 35'(dy_w);
    assign ndx  = -dxq;

    always_comb
    begin
        if (dxq == 35'sd0 && dyq == 35'sd0)
        begin
            k_w = 2'd3;
        end
        else if (dyq > ndx && dyq <= dxq)
        begin
            k_w = 2'd3;
        end
        else if (dyq > dxq && dyq >= ndx)
        begin
            k_w = 2'd2;
        end
        else if (dyq <= ndx && dyq < dxq)
        begin
            k_w = 2'd0;
        end
        else
        begin
            k_w = 2'd1;
        end
    end

    assign sum_w = acc_reg + prod_reg;
    assign dif_w = acc_reg - prod_reg;

    // binning
    assign offr   = vr_reg + BinLow;
    assign offd   = d_reg + BinLow;
    assign bin_pr = 20'(offr[41:32]) * 20'(svmh_pkg::VBIN_RECIP);
    assign bin_pa = 20'(offd[41:32]) * 20'(svmh_pkg::VBIN_RECIP);
    assign bin_i  = bin_pr[svmh_pkg::VBIN_RECIP_SHIFT +: BW];
    assign bin_j  = bin_pa[svmh_pkg::VBIN_RECIP_SHIFT +: BW];

    assign va_w   = (prod_reg > VaLimit) ? VaLimit :
                    ((prod_reg < -VaLimit) ? -VaLimit : prod_reg);
    assign cv_ext = 66'($signed(cfg.circular_velocity)) <<< 16;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        px_next = px_reg; py_next = py_reg;
        vx_next = vx_reg; vy_next = vy_reg;
        ax_next = ax_reg; ay_next = ay_reg; az_next = az_reg;
        acc_next = acc_reg; acc2_next = acc2_reg; na_next = na_reg;
        vr_next = vr_reg; d_next = d_reg;
        rad_next = rad_reg; root_next = root_reg; rem_next = rem_reg;
        cx_next = cx_reg; cy_next = cy_reg; ang_next = ang_reg;
        dvd_next = dvd_reg; drem_next = drem_reg; dneg_next = dneg_reg;
        srv_next = srv_reg; sav_next = sav_reg;
        k_next = k_reg;
        job_next = job_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (push && !hold)
                begin
                    job_next.kind     = svmh_pkg::JOB_REJECT;
                    job_next.quad     = 2'd0;
                    job_next.vr       = '0;
                    job_next.va       = '0;
                    job_next.in_range = 1'b0;
                    px_next = pos_x; py_next = pos_y;
                    vx_next = vel_x; vy_next = vel_y;
                    cnt_next = '0;
                    if (opcode == svmh_pkg::OP_READ)
                    begin
                        job_next.kind     = svmh_pkg::JOB_READ;
                        job_next.quad     = read_quadrant;
                        job_next.vr       = BW'(read_vr_bin);
                        job_next.va       = BW'(read_va_bin);
                        job_next.in_range = (32'(read_quadrant) < 32'(QUADRANTS))
                                         && (32'(read_vr_bin) < 32'(VR_BINS))
                                         && (32'(read_va_bin) < 32'(VA_BINS));
                        state_next = S_EMIT;
                    end
                    else if (pos_y[31])
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        ax_next = ax_mag[31:0];
                        ay_next = ay_mag[31:0];
                        az_next = az_mag[31:0];
                        state_next = S_SQ;
                    end
                end
            end
            S_SQ:
            begin
                cnt_next = cnt_reg + 7'd1;
                case (cnt_reg[2:0])
                    3'd1: acc_next = prod_reg;
                    3'd2:
                    begin
                        acc_next  = sum_w;
                        acc2_next = sum_w;
                    end
                    3'd3: acc_next = sum_w;
                    3'd4:
                    begin
                        cnt_next = '0;
                        if (acc_reg > prod_reg)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            rad_next   = acc2_reg[63:0];
                            root_next  = '0;
                            rem_next   = '0;
                            state_next = S_SQRT1;
                        end
                    end
                    default: acc_next = acc_reg;
                endcase
            end
            S_SQRT1, S_SQRT2:
            begin
                rad_next  = {rad_reg[61:0], 2'b00};
                root_next = root_step;
                rem_next  = rem_step;
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == SqrtLast)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == S_SQRT1) ? S_CINIT : S_VINIT;
                end
            end
            S_CINIT:
            begin
                cx_next  = 60'({root_reg, 24'd0});
                cy_next  = 60'({az_reg, 24'd0});
                ang_next = '0;
                cnt_next = '0;
                if (root_reg == '0)
                begin
                    // on the z axis through the sun point: latitude is 0 or a right angle
                    ang_next   = (az_reg == '0) ? '0 : RightAngle;
                    state_next = S_LAT;
                end
                else
                begin
                    state_next = S_CORDIC;
                end
            end
            S_CORDIC:
            begin
                if (!cy_reg[59])
                begin
                    cx_next  = cx_reg + ys;
                    cy_next  = cy_reg - xs;
                    ang_next = ang_reg + atan_w;
                end
                else
                begin
                    cx_next  = cx_reg - ys;
                    cy_next  = cy_reg + xs;
                    ang_next = ang_reg - atan_w;
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == CordicLast)
                begin
                    cnt_next   = '0;
                    state_next = S_LAT;
                end
            end
            S_LAT:
            begin
                cnt_next = '0;
                if (ang_reg > $signed({2'b00, cfg.latitude_limit}))
                begin
                    state_next = S_EMIT;
                end
                else if (32'(k_w) >= 32'(QUADRANTS))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    k_next     = k_w;
                    state_next = S_GSQ;
                end
            end
            S_GSQ:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    acc_next = prod_reg;
                end
                else if (cnt_reg == 7'd2)
                begin
                    rad_next   = sum_w[63:0];
                    root_next  = '0;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_SQRT2;
                end
            end
            S_VINIT:
            begin
                cnt_next = '0;
                if (root_reg == '0)
                begin
                    // on the galactic axis both velocities are zero
                    vr_next    = '0;
                    d_next     = -cv_ext;
                    state_next = S_BIN;
                end
                else
                begin
                    state_next = S_VMUL;
                end
            end
            S_VMUL:
            begin
                cnt_next = cnt_reg + 7'd1;
                case (cnt_reg[2:0])
                    3'd1: acc_next = prod_reg;
                    3'd2: acc2_next = sum_w;
                    3'd3: acc_next = prod_reg;
                    3'd4:
                    begin
                        na_next    = dif_w;
                        dneg_next  = acc2_reg[65];
                        dvd_next   = mag66(acc2_reg);
                        drem_next  = '0;
                        cnt_next   = '0;
                        state_next = S_DIV1;
                    end
                    default: acc_next = acc_reg;
                endcase
            end
            S_DIV1:
            begin
                dvd_next  = dvd_step;
                drem_next = drem_step;
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == DivLast)
                begin
                    srv_next   = sat_quot(dvd_step, dneg_reg);
                    dneg_next  = na_reg[65];
                    dvd_next   = mag66(na_reg);
                    drem_next  = '0;
                    cnt_next   = '0;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                dvd_next  = dvd_step;
                drem_next = drem_step;
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == DivLast)
                begin
                    sav_next   = sat_quot(dvd_step, dneg_reg);
                    cnt_next   = '0;
                    state_next = S_SMUL;
                end
            end
            S_SMUL:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    vr_next = -prod_reg;
                end
                else if (cnt_reg == 7'd2)
                begin
                    d_next     = va_w - cv_ext;
                    cnt_next   = '0;
                    state_next = S_BIN;
                end
            end
            S_BIN:
            begin
                if (!(offr[65] || offr >= VrSpan || offd[65] || offd >= VaSpan))
                begin
                    job_next.kind = svmh_pkg::JOB_COUNT;
                    job_next.quad = k_reg;
                    job_next.vr   = bin_i;
                    job_next.va   = bin_j;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!job_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next; py_reg <= py_next;
        vx_reg <= vx_next; vy_reg <= vy_next;
        ax_reg <= ax_next; ay_reg <= ay_next; az_reg <= az_next;
        prod_reg <= prod_w;
        acc_reg <= acc_next; acc2_reg <= acc2_next; na_reg <= na_next;
        vr_reg <= vr_next; d_reg <= d_next;
        rad_reg <= rad_next; root_reg <= root_next; rem_reg <= rem_next;
        cx_reg <= cx_next; cy_reg <= cy_next; ang_reg <= ang_next;
        dvd_reg <= dvd_next; drem_reg <= drem_next; dneg_reg <= dneg_next;
        srv_reg <= srv_next; sav_reg <= sav_next;
        k_reg <= k_next;
        job_reg <= job_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/svmh_back.sv @@
// Back end: histogram store with read-modify-write update, running total and
// result register. Clears the store after reset. Depends on svmh_pkg.
`default_nettype none

module svmh_back #(
    parameter int QUADRANTS   = svmh_pkg::QUADRANTS_DEF,
    parameter int VR_BINS     = svmh_pkg::VR_BINS_DEF,
    parameter int VA_BINS     = svmh_pkg::VA_BINS_DEF,
    parameter int COUNT_WIDTH = svmh_pkg::COUNT_WIDTH_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   job_empty,
    output logic                  job_pop,
    input  svmh_pkg::svmh_job_t   job,
    output logic                  clearing,
    output logic                  empty,
    input  wire                   pop,
    output logic                  accepted,
    output logic [1:0]            quadrant,
    output logic [6:0]            vr_bin,
    output logic [6:0]            va_bin,
    output logic [31:0]           bin_count,
    output logic [31:0]           total_counted
);

    localparam int DEPTH = QUADRANTS * VR_BINS * VA_BINS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_READ  = 4'b0100,
        B_UPD   = 4'b1000
    } bstate_t;

    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [COUNT_WIDTH-1:0] mem_rdata_reg;

    bstate_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] addr_reg, addr_next;
    svmh_pkg::svmh_job_t cur_reg, cur_next;
    logic [31:0] total_reg, total_next;
    logic out_valid_reg, out_valid_next;
    logic out_acc_reg, out_acc_next;
    logic [1:0] out_quad_reg, out_quad_next;
    logic [6:0] out_vr_reg, out_vr_next, out_va_reg, out_va_next;
    logic [COUNT_WIDTH-1:0] out_cnt_reg, out_cnt_next;
    logic [31:0] out_tot_reg, out_tot_next;

    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata, new_cnt;
    logic [31:0] job_addr;

    assign clearing      = (state_reg == B_CLEAR);
    assign empty         = !out_valid_reg;
    assign accepted      = out_acc_reg;
    assign quadrant      = out_quad_reg;
    assign vr_bin        = out_vr_reg;
    assign va_bin        = out_va_reg;
    assign bin_count     = 32'(out_cnt_reg);
    assign total_counted = out_tot_reg;

    assign job_addr = (32'(job.quad) * 32'(VR_BINS) + 32'(job.vr)) * 32'(VA_BINS)
                    + 32'(job.va);
    assign new_cnt  = (mem_rdata_reg == CountMax) ? mem_rdata_reg
                                                  : mem_rdata_reg + COUNT_WIDTH'(1);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        addr_next      = addr_reg;
        cur_next       = cur_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        out_acc_next   = out_acc_reg;
        out_quad_next  = out_quad_reg;
        out_vr_next    = out_vr_reg;
        out_va_next    = out_va_reg;
        out_cnt_next   = out_cnt_reg;
        out_tot_next   = out_tot_reg;
        job_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = new_cnt;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!job_empty && !out_valid_reg)
                begin
                    job_pop   = 1'b1;
                    cur_next  = job;
                    addr_next = job_addr[AW-1:0];
                    case (job.kind)
                        svmh_pkg::JOB_COUNT:
                        begin
                            state_next = B_READ;
                        end
                        svmh_pkg::JOB_READ:
                        begin
                            if (job.in_range)
                            begin
                                state_next = B_READ;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                out_acc_next   = 1'b0;
                                out_quad_next  = job.quad;
                                out_vr_next    = job.vr[6:0];
                                out_va_next    = job.va[6:0];
                                out_cnt_next   = '0;
                                out_tot_next   = total_reg;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_acc_next   = 1'b0;
                            out_quad_next  = 2'd0;
                            out_vr_next    = 7'd0;
                            out_va_next    = 7'd0;
                            out_cnt_next   = '0;
                            out_tot_next   = total_reg;
                        end
                    endcase
                end
            end
            B_READ:
            begin
                state_next = B_UPD;
            end
            B_UPD:
            begin
                out_valid_next = 1'b1;
                out_quad_next  = cur_reg.quad;
                out_vr_next    = cur_reg.vr[6:0];
                out_va_next    = cur_reg.va[6:0];
                if (cur_reg.kind == svmh_pkg::JOB_COUNT)
                begin
                    mem_we       = 1'b1;
                    total_next   = (total_reg == 32'hFFFF_FFFF) ? total_reg
                                                                : total_reg + 32'd1;
                    out_acc_next = 1'b1;
                    out_cnt_next = new_cnt;
                    out_tot_next = total_next;
                end
                else
                begin
                    out_acc_next = 1'b0;
                    out_cnt_next = mem_rdata_reg;
                    out_tot_next = total_reg;
                end
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        cur_reg      <= cur_next;
        out_acc_reg  <= out_acc_next;
        out_quad_reg <= out_quad_next;
        out_vr_reg   <= out_vr_next;
        out_va_reg   <= out_va_next;
        out_cnt_reg  <= out_cnt_next;
        out_tot_reg  <= out_tot_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[addr_reg];
    end

endmodule

`default_nettype wire
